>>> src/lru_cache_replacement_core_defines.svh
// ----------------------------------------------------------------------------
// lru_cache_replacement_core_defines
// assertion macros used by the lru cache checker file
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_REPLACEMENT_CORE_DEFINES_SVH
`define LRU_CACHE_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LRUC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lru cache check failed");

// next-cycle implication, disabled while in reset
`define LRUC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lru cache check failed");

`endif

>>> src/lruc_pkg.sv
// ----------------------------------------------------------------------------
// lruc_pkg
// shared types and fixed widths of the lru cache tag store
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int unsigned REQ_KEY_W = 8;
    localparam int unsigned WAY_OUT_W = 3;
    localparam int unsigned COUNT_W   = 32;

    typedef struct packed {
        logic load_key;
        logic commit;
    } lruc_cmd_t;

endpackage

>>> src/lruc_ctrl.sv
// ----------------------------------------------------------------------------
// lruc_ctrl
// handshake controller: takes a request beat, commits it to the datapath
// once the result register is free
// ----------------------------------------------------------------------------
module lruc_ctrl
    import lruc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output lruc_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic can_commit;
    logic req_take;

    assign can_commit = (state_reg == S_BUSY) && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = (state_reg == S_IDLE) || can_commit;
    assign req_take   = req_valid && req_ready;
    assign rsp_valid  = rsp_valid_reg;

    always_comb
    begin
        cmd.load_key = req_take;
        cmd.commit   = can_commit;
        state_next   = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (can_commit)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = req_take ? S_BUSY : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> src/lruc_dp.sv
// ----------------------------------------------------------------------------
// lruc_dp
// tag store datapath: parallel key compare, victim choice, age rank update
// and saturating hit and miss counters
// ----------------------------------------------------------------------------
module lruc_dp
    import lruc_pkg::*;
#(
    parameter int unsigned WAYS     = 8,
    parameter int unsigned KEY_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lruc_cmd_t            cmd,
    input  logic [REQ_KEY_W-1:0] request_key,
    output logic                 hit,
    output logic [WAY_OUT_W-1:0] way_used,
    output logic [COUNT_W-1:0]   hit_total,
    output logic [COUNT_W-1:0]   miss_total
);

    localparam int unsigned KEY_W  = (KEY_BITS < REQ_KEY_W) ? KEY_BITS : REQ_KEY_W;
    localparam int unsigned WAY_W  = $clog2(WAYS);
    localparam int unsigned RANK_W = $clog2(WAYS);
    localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(WAYS - 1);

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   way_key_reg [WAYS];
    logic [WAYS-1:0]    way_valid_reg;
    logic [WAYS-1:0]    way_valid_next;
    logic [RANK_W-1:0]  way_rank_reg  [WAYS];
    logic [RANK_W-1:0]  way_rank_next [WAYS];
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] misses_reg;
    logic               hit_reg;
    logic [WAY_OUT_W-1:0] way_used_reg;

    logic [WAYS-1:0]    match;
    logic               lookup_hit;
    logic [WAY_W-1:0]   hit_idx;
    logic [WAY_W-1:0]   empty_idx;
    logic               any_empty;
    logic [WAY_W-1:0]   lru_idx;
    logic [WAY_W-1:0]   way_sel;
    logic               sel_was_valid;
    logic [RANK_W-1:0]  sel_rank;
    logic [WAY_W+WAY_OUT_W-1:0] way_wide;

    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        lru_idx   = '0;
        any_empty = 1'b0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            match[i] = way_valid_reg[i] && (way_key_reg[i] == key_reg);
            if (match[i])
            begin
                hit_idx = WAY_W'(i);
            end
            if (!way_valid_reg[i])
            begin
                empty_idx = WAY_W'(i);
                any_empty = 1'b1;
            end
            if (way_rank_reg[i] == RANK_OLDEST)
            begin
                lru_idx = WAY_W'(i);
            end
        end
        lookup_hit = |match;
        way_sel    = lookup_hit ? hit_idx : (any_empty ? empty_idx : lru_idx);
        sel_was_valid = way_valid_reg[way_sel];
        sel_rank      = way_rank_reg[way_sel];
    end

    // promote the chosen way, ageing the younger valid ways
    always_comb
    begin
        way_valid_next = way_valid_reg;
        for (int i = 0; i < WAYS; i++)
        begin
            way_rank_next[i] = way_rank_reg[i];
            if ((WAY_W'(i) != way_sel) && way_valid_reg[i]
                && (!sel_was_valid || (way_rank_reg[i] < sel_rank))
                && (way_rank_reg[i] < RANK_OLDEST))
            begin
                way_rank_next[i] = way_rank_reg[i] + 1'b1;
            end
        end
        way_rank_next[way_sel]  = '0;
        way_valid_next[way_sel] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= request_key[KEY_W-1:0];
        end
        if (cmd.commit && !lookup_hit)
        begin
            way_key_reg[way_sel] <= key_reg;
        end
        if (cmd.commit)
        begin
            hit_reg      <= lookup_hit;
            way_used_reg <= way_wide[WAY_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_valid_reg <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            for (int i = 0; i < WAYS; i++)
            begin
                way_rank_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            way_valid_reg <= way_valid_next;
            way_rank_reg  <= way_rank_next;
            if (lookup_hit && (hits_reg != '1))
            begin
                hits_reg <= hits_reg + 1'b1;
            end
            if (!lookup_hit && (misses_reg != '1))
            begin
                misses_reg <= misses_reg + 1'b1;
            end
        end
    end

    assign way_wide   = {{WAY_OUT_W{1'b0}}, way_sel};
    assign hit        = hit_reg;
    assign way_used   = way_used_reg;
    assign hit_total  = hits_reg;
    assign miss_total = misses_reg;

endmodule

>>> src/lru_cache_replacement_core.sv
// ----------------------------------------------------------------------------
// lru_cache_replacement_core
// Fully associative tag store with true LRU replacement. Each request beat
// carries a key that is compared against every valid way at once; a hit
// promotes that way, a miss fills the lowest empty way or evicts the oldest
// one. The response beat gives hit or miss, the way used and saturating hit
// and miss totals. A request is taken into the key register and committed
// from the BUSY state once the response register is free; the commit loads
// the response register, which drives the response beat. One request per
// clock is sustained as long as responses are taken; the compare, victim
// select and age-rank update across all ways are combinational and allow it.
// ----------------------------------------------------------------------------
module lru_cache_replacement_core
    import lruc_pkg::*;
#(
    parameter int unsigned WAYS     = 8,
    parameter int unsigned KEY_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [REQ_KEY_W-1:0] request_key,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic                 hit,
    output logic [WAY_OUT_W-1:0] way_used,
    output logic [COUNT_W-1:0]   hit_total,
    output logic [COUNT_W-1:0]   miss_total
);

    lruc_cmd_t cmd;

    lruc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    lruc_dp #(
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .request_key (request_key),
        .hit         (hit),
        .way_used    (way_used),
        .hit_total   (hit_total),
        .miss_total  (miss_total)
    );

endmodule

>>> src/lruc_checker.sv
// ----------------------------------------------------------------------------
// lruc_checker
// port-level checks on the lru cache tag store, bound to the top level
// ----------------------------------------------------------------------------
`include "lru_cache_replacement_core_defines.svh"

module lruc_checker
    import lruc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic [REQ_KEY_W-1:0] request_key,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic                 hit,
    input logic [WAY_OUT_W-1:0] way_used,
    input logic [COUNT_W-1:0]   hit_total,
    input logic [COUNT_W-1:0]   miss_total
);

    logic rsp_stall;
    logic req_stall;

    assign rsp_stall = rsp_valid && !rsp_ready;
    assign req_stall = req_valid && !req_ready;

    `LRUC_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_stall,
        rsp_valid && $stable(hit) && $stable(way_used)
        && $stable(hit_total) && $stable(miss_total))
    `LRUC_ASSERT_NXT(a_req_hold, clk, rst_n, req_stall,
        req_valid && $stable(request_key))
    `LRUC_ASSERT_NXT(a_totals_mono, clk, rst_n, 1'b1,
        hit_total >= $past(hit_total) && miss_total >= $past(miss_total))
    `LRUC_ASSERT_IMP(a_hit_counted, clk, rst_n, rsp_valid && hit, hit_total != '0)
    `LRUC_ASSERT_IMP(a_miss_counted, clk, rst_n, rsp_valid && !hit, miss_total != '0)

endmodule

bind lru_cache_replacement_core lruc_checker u_lruc_checker (.*);

>>> dv/lru_tag_model_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_tag_model_pkg
// Scoreboard for the lru cache tag store. It keeps its own copy of the ways,
// their age ranks and the hit and miss totals, works out the response to each
// accepted request beat and checks response beats in order, field by field.
// ----------------------------------------------------------------------------
package lru_tag_model_pkg;

    import lruc_pkg::*;

    localparam int unsigned NUM_WAYS = 8;
    localparam int unsigned RANK_W   = 3;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [COUNT_W-1:0]   hits;
        logic [COUNT_W-1:0]   misses;
    } cache_rsp_t;

    class lru_tag_model;

        logic [REQ_KEY_W-1:0] key_of   [NUM_WAYS];
        bit                   valid_of [NUM_WAYS];
        logic [RANK_W-1:0]    rank_of  [NUM_WAYS];
        logic [COUNT_W-1:0]   hit_count;
        logic [COUNT_W-1:0]   miss_count;
        cache_rsp_t           pending_rsp[$];
        int unsigned          errors;

        function new();
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                key_of[i]   = '0;
                valid_of[i] = 1'b0;
                rank_of[i]  = '0;
            end
            hit_count  = '0;
            miss_count = '0;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return pending_rsp.size();
        endfunction

        function void take_request(input logic [REQ_KEY_W-1:0] key);
            int                unsigned w;
            bit                is_hit;
            bit                found;
            bit                was_valid;
            logic [RANK_W-1:0] old_rank;
            cache_rsp_t        rsp;
            w      = 0;
            is_hit = 1'b0;
            found  = 1'b0;
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                if (!is_hit && valid_of[i] && key_of[i] == key)
                begin
                    w      = i;
                    is_hit = 1'b1;
                end
            end
            if (is_hit)
            begin
                if (hit_count != '1)
                    hit_count++;
            end
            else
            begin
                for (int i = 0; i < NUM_WAYS; i++)
                begin
                    if (!found && !valid_of[i])
                    begin
                        w     = i;
                        found = 1'b1;
                    end
                end
                // all ways full: evict the oldest, lowest index on a tie
                if (!found)
                begin
                    w = 0;
                    for (int i = 1; i < NUM_WAYS; i++)
                        if (rank_of[i] > rank_of[w])
                            w = i;
                end
                if (miss_count != '1)
                    miss_count++;
                key_of[w] = key;
            end
            // promote way w, everything younger ages by one
            was_valid = valid_of[w];
            old_rank  = rank_of[w];
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                if (i != w && valid_of[i] && (!was_valid || rank_of[i] < old_rank))
                    if (rank_of[i] < NUM_WAYS - 1)
                        rank_of[i]++;
            end
            rank_of[w]  = '0;
            valid_of[w] = 1'b1;
            rsp.hit    = is_hit;
            rsp.way    = w[WAY_OUT_W-1:0];
            rsp.hits   = hit_count;
            rsp.misses = miss_count;
            pending_rsp.push_back(rsp);
        endfunction

        function void check_response(input cache_rsp_t got);
            cache_rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response beat with none pending: hit=%0d way=%0d hits=%0d misses=%0d",
                         $time, got.hit, got.way, got.hits, got.misses);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.hit !== want.hit)
            begin
                $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.way !== want.way)
            begin
                $display("%0t: way_used expected %0d actual %0d", $time, want.way, got.way);
                errors++;
            end
            if (got.hits !== want.hits)
            begin
                $display("%0t: hit_total expected %0d actual %0d", $time, want.hits, got.hits);
                errors++;
            end
            if (got.misses !== want.misses)
            begin
                $display("%0t: miss_total expected %0d actual %0d",
                         $time, want.misses, got.misses);
                errors++;
            end
        endfunction

    endclass

endpackage

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives request beats into the lru cache tag store and takes its response
// beats with random gaps and stalls on both sides. A short directed run
// covers extreme keys, filling, hits on three ways and eviction, then random
// runs over working sets of varying size exercise hits, fills and lru
// eviction, including a full-rate burst and a long response back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    import lruc_pkg::*;
    import lru_tag_model_pkg::*;

    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned LONG_HOLD  = 150;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic [REQ_KEY_W-1:0] request_key = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic [COUNT_W-1:0]   hit_total;
    logic [COUNT_W-1:0]   miss_total;

    lru_tag_model model = new();
    bit           free_flow = 1'b0;
    bit           hold_request = 1'b0;

    lru_cache_replacement_core #(
        .WAYS     (NUM_WAYS),
        .KEY_BITS (REQ_KEY_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .request_key (request_key),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .hit         (hit),
        .way_used    (way_used),
        .hit_total   (hit_total),
        .miss_total  (miss_total)
    );

    always #6 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [REQ_KEY_W-1:0] pick_key(input int unsigned base,
                                                      input int unsigned span);
        if ($urandom_range(0, 9) < 8)
            return REQ_KEY_W'(base + $urandom_range(0, span - 1));
        return REQ_KEY_W'($urandom_range(0, 255));
    endfunction

    task automatic send_key(input logic [REQ_KEY_W-1:0] k);
        @(negedge clk);
        req_valid   <= 1'b1;
        request_key <= k;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic pause_req(input int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_gapped(input logic [REQ_KEY_W-1:0] k);
        send_key(k);
        pause_req(free_flow ? 0 : pick_gap());
    endtask

    task automatic wait_drained();
        pause_req(1);
        while (model.pending() != 0)
            @(posedge clk);
    endtask

    // response side: random stalls, a long hold-off on request
    initial
    begin
        int unsigned run_left;
        int unsigned stall_left;
        int unsigned hold_left;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else if (free_flow)
                rsp_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                rsp_ready <= 1'b1;
                run_left--;
            end
            else
            begin
                rsp_ready  <= 1'b1;
                run_left   = $urandom_range(0, 15);
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cache_rsp_t got;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                got.hit    = hit;
                got.way    = way_used;
                got.hits   = hit_total;
                got.misses = miss_total;
                model.check_response(got);
            end
            if (req_valid && req_ready)
                model.take_request(request_key);
        end
    end

    // watchdog on beats of either channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((req_valid && req_ready) || (rsp_valid && rsp_ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [REQ_KEY_W-1:0] directed[$];
        int unsigned          base;
        int unsigned          span;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes, fill, hits on three of the ways, eviction of the oldest
        directed = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h80, 8'h55,
                     8'h55, 8'hFF, 8'hAA, 8'h00, 8'h7F, 8'h01, 8'h02, 8'h08, 8'h04,
                     8'h80, 8'hAA, 8'h55, 8'hFE, 8'hFF, 8'h01};
        foreach (directed[i])
            send_gapped(directed[i]);
        wait_drained();

        // full rate, no stalls
        free_flow = 1'b1;
        base      = $urandom_range(0, 255);
        for (int i = 0; i < 200; i++)
            send_gapped(pick_key(base, 10));
        wait_drained();
        free_flow = 1'b0;

        // long response hold-off while requests keep coming
        hold_request = 1'b1;
        base         = $urandom_range(0, 255);
        for (int i = 0; i < 60; i++)
            send_key(pick_key(base, 12));
        wait_drained();

        for (int c = 0; c < 5; c++)
        begin
            base = $urandom_range(0, 255);
            span = $urandom_range(2, 14);
            for (int i = 0; i < 310; i++)
                send_gapped(pick_key(base, span));
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (model.errors == 0 && model.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
